// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker in ptw_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clk edge while out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another property at the same edge.
`define ASSERT_IMPLY(label, cond, prop, msg) \
    `ASSERT_CLK(label, (cond) |-> (prop), msg)

// Check that a condition implies another property at the next edge.
`define ASSERT_NEXT(label, cond, prop, msg) \
    `ASSERT_CLK(label, (cond) |=> (prop), msg)

`endif

// ===== hdl/ptw_pkg.sv =====
`default_nettype none

package ptw_pkg;

    localparam logic [31:0] DIR_BASE_RESET = 32'h0003_9000;
    localparam logic [12:0] PAGE_BYTES     = 13'h1000;

    localparam logic REQ_TRANSLATE = 1'b0;
    localparam logic REQ_RESPONSE  = 1'b1;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [31:0] virt_addr;
        logic [15:0] access_length;
        logic [31:0] read_data;
    } ptw_item_t;

    typedef struct packed {
        logic        out_kind;
        logic [31:0] read_addr;
        logic [31:0] phys_addr;
        logic [12:0] clipped_length;
        logic        walk_fault;
    } ptw_result_t;

endpackage

`default_nettype wire

// ===== hdl/ptw_in_stage.sv =====
`default_nettype none

module ptw_in_stage
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire ptw_pkg::ptw_item_t in_item,
    input  wire logic               take,
    output logic                    item_valid,
    output ptw_pkg::ptw_item_t      item
);

    logic               valid_reg;
    logic               valid_next;
    ptw_pkg::ptw_item_t item_reg;
    logic               load;

    // Hold a beat here until the walk step consumes it.
    assign in_stall = valid_reg && !take;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== hdl/ptw_walk_step.sv =====
`default_nettype none

module ptw_walk_step
#(
    parameter int unsigned MAX_ACCESS = 32768
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step_en,
    input  wire ptw_pkg::ptw_item_t   item,
    input  wire logic [31:0]          dir_base,
    output logic                      res_valid,
    output ptw_pkg::ptw_result_t      res
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PDE  = 2'd1,
        PH_PTE  = 2'd2
    } phase_t;

    localparam logic [15:0] MaxLen = 16'(MAX_ACCESS);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [31:0] vaddr_reg;
    logic [31:0] vaddr_next;
    logic [15:0] length_reg;
    logic [15:0] length_next;

    logic        busy;
    logic [16:0] clip_sum;
    logic [12:0] clip_len;

    // Both page sizes clip at the 4 KB page end, using va[11:0] as the offset.
    assign clip_sum = {5'b0, vaddr_reg[11:0]} + {1'b0, length_reg};
    assign clip_len = (clip_sum > 17'(ptw_pkg::PAGE_BYTES))
                    ? ptw_pkg::PAGE_BYTES - {1'b0, vaddr_reg[11:0]}
                    : length_reg[12:0];

    assign busy = (phase_reg == PH_PDE) || (phase_reg == PH_PTE);

    always_comb
    begin
        phase_next  = phase_reg;
        vaddr_next  = vaddr_reg;
        length_next = length_reg;
        res_valid   = 1'b0;
        res         = '0;
        if (item.req_type == ptw_pkg::REQ_TRANSLATE)
        begin
            if (!busy)
            begin
                res_valid   = 1'b1;
                vaddr_next  = item.virt_addr;
                length_next = (item.access_length > MaxLen) ? MaxLen : item.access_length;
                if (dir_base[11:0] != 12'h000)
                begin
                    res.out_kind   = ptw_pkg::KIND_DONE;
                    res.walk_fault = 1'b1;
                    phase_next     = PH_IDLE;
                end
                else
                begin
                    res.out_kind  = ptw_pkg::KIND_READ;
                    res.read_addr = {dir_base[31:12], item.virt_addr[31:22], 2'b00};
                    phase_next    = PH_PDE;
                end
            end
        end
        else
        begin
            case (phase_reg)
                PH_PDE:
                begin
                    res_valid = 1'b1;
                    if (!item.read_data[0])
                    begin
                        res.out_kind   = ptw_pkg::KIND_DONE;
                        res.walk_fault = 1'b1;
                        phase_next     = PH_IDLE;
                    end
                    else if (item.read_data[7])
                    begin
                        res.out_kind       = ptw_pkg::KIND_DONE;
                        res.phys_addr      = {item.read_data[31:22], vaddr_reg[21:0]};
                        res.clipped_length = clip_len;
                        phase_next         = PH_IDLE;
                    end
                    else
                    begin
                        res.out_kind  = ptw_pkg::KIND_READ;
                        res.read_addr = {item.read_data[31:12], vaddr_reg[21:12], 2'b00};
                        phase_next    = PH_PTE;
                    end
                end
                PH_PTE:
                begin
                    res_valid  = 1'b1;
                    res.out_kind = ptw_pkg::KIND_DONE;
                    phase_next = PH_IDLE;
                    if (!item.read_data[0])
                    begin
                        res.walk_fault = 1'b1;
                    end
                    else
                    begin
                        res.phys_addr      = {item.read_data[31:12], vaddr_reg[11:0]};
                        res.clipped_length = clip_len;
                    end
                end
                default:
                begin
                    // Drop a response that arrives while idle.
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            vaddr_reg  <= '0;
            length_reg <= '0;
        end
        else if (step_en)
        begin
            phase_reg  <= phase_next;
            vaddr_reg  <= vaddr_next;
            length_reg <= length_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ptw_out_stage.sv =====
`default_nettype none

module ptw_out_stage
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire ptw_pkg::ptw_result_t res_in,
    output logic                      slot_free,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output ptw_pkg::ptw_result_t      res_out
);

    logic                 valid_reg;
    logic                 valid_next;
    ptw_pkg::ptw_result_t res_reg;

    // The slot frees in the same cycle the receiver takes the beat.
    assign slot_free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

`default_nettype wire

// ===== hdl/two_level_page_walker_core.sv =====
// Two-level page walker, 4 KB pages and 4 MB large pages.
// Input channel (in_valid / in_stall): one beat is either a translate request
// (req_type 0, virt_addr, access_length) or a memory response (req_type 1,
// read_data) to the last read this block issued.
// Output channel (out_valid / out_stall): one beat is either a read request
// (out_kind 0, read_addr) for the caller to send to memory, or a finished
// translation (out_kind 1) with phys_addr, clipped_length and walk_fault.
// Each accepted beat yields at most one result beat, which passes the input register, then
// the result register; a beat may be accepted every cycle while in_stall is low.
// A walk takes one request and up to two responses; its latency is set by
// the memory behind the caller. Requests during a walk and responses while
// idle are dropped with no result.
// cfg_we / cfg_wdata write page_dir_base; write it only while no walk is open.
// Reset clears the walk, the beats in flight, and sets page_dir_base to
// 0x39000. While out_stall is high the result is held, and in_stall rises
// as soon as the input register also holds a beat.
`default_nettype none

module two_level_page_walker_core
#(
    parameter int unsigned MAX_ACCESS = 32768
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        req_type,
    input  wire logic [31:0] virt_addr,
    input  wire logic [15:0] access_length,
    input  wire logic [31:0] read_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             out_kind,
    output logic [31:0]      read_addr,
    output logic [31:0]      phys_addr,
    output logic [12:0]      clipped_length,
    output logic             walk_fault
);

    logic [31:0]          dir_base_reg;
    ptw_pkg::ptw_item_t   in_item;
    ptw_pkg::ptw_item_t   item;
    logic                 item_valid;
    logic                 step_en;
    logic                 slot_free;
    logic                 res_valid;
    ptw_pkg::ptw_result_t res;
    ptw_pkg::ptw_result_t res_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_base_reg <= ptw_pkg::DIR_BASE_RESET;
        end
        else if (cfg_we)
        begin
            dir_base_reg <= cfg_wdata;
        end
    end

    assign in_item.req_type      = req_type;
    assign in_item.virt_addr     = virt_addr;
    assign in_item.access_length = access_length;
    assign in_item.read_data     = read_data;

    // Advance a held beat only when the result register can take its result.
    assign step_en = item_valid && slot_free;

    ptw_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .take       (step_en),
        .item_valid (item_valid),
        .item       (item)
    );

    ptw_walk_step #(.MAX_ACCESS(MAX_ACCESS)) u_walk
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .item      (item),
        .dir_base  (dir_base_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    ptw_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step_en && res_valid),
        .res_in    (res),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_out   (res_out)
    );

    assign out_kind       = res_out.out_kind;
    assign read_addr      = res_out.read_addr;
    assign phys_addr      = res_out.phys_addr;
    assign clipped_length = res_out.clipped_length;
    assign walk_fault     = res_out.walk_fault;

endmodule

`default_nettype wire

// ===== hdl/ptw_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module ptw_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        out_kind,
    input wire logic [31:0] read_addr,
    input wire logic [31:0] phys_addr,
    input wire logic [12:0] clipped_length,
    input wire logic        walk_fault
);

    `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result beat dropped")
    `ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_kind) && $stable(read_addr) && $stable(phys_addr) && $stable(clipped_length) && $stable(walk_fault), "stalled result beat changed")
    `ASSERT_IMPLY(a_read_clean, out_valid && !out_kind, phys_addr == 32'h0 && clipped_length == 13'h0 && !walk_fault, "read beat carries translation fields")
    `ASSERT_IMPLY(a_fault_clean, out_valid && walk_fault, out_kind && phys_addr == 32'h0 && clipped_length == 13'h0, "fault beat carries a translation")
    `ASSERT_IMPLY(a_page_clip, out_valid && out_kind && !walk_fault, ({1'b0, clipped_length} + {2'b00, phys_addr[11:0]}) <= 14'd4096, "length crosses the 4 KB page end")

endmodule

bind two_level_page_walker_core ptw_checker u_ptw_checker (.*);

`default_nettype wire
